>>> design/opls_pkg.sv
// Shared types, codes, constants and arithmetic helpers of the oil pressure and limp supervisor.
`default_nettype none

package opls_pkg;

  // Engine speed at and above which the engine counts as running.
  localparam logic [15:0] RUN_RPM = 16'd400;

  // Bits that the supervisor adds to the sensor fault word.
  localparam logic [7:0] FAULT_EXPANDER_BIT = 8'h40;
  localparam logic [7:0] FAULT_OIL_BIT      = 8'h80;

  // Lowest advance allowed while limp mode is latched.
  localparam logic signed [10:0] ADV_FLOOR = -11'sd100;

  // Sender offset of 0.5 V in ADC counts, times ten.
  localparam logic signed [17:0] ADC_OFFSET_X10 = 18'sd4095;

  // Reciprocal of 819 for an exact floor division of a 22-bit value.
  localparam logic [22:0] DIV819_RECIP = 23'd5244161;

  typedef enum logic [1:0] {
    ENG_OFF   = 2'd0,
    ENG_CRANK = 2'd1,
    ENG_RUN   = 2'd2
  } engine_state_e;

  typedef enum logic [1:0] {
    OIL_OFF    = 2'd0,
    OIL_SWITCH = 2'd1,
    OIL_ANALOG = 2'd2
  } oil_mode_e;

  typedef enum logic [2:0] {
    REG_OIL_MODE       = 3'd0,
    REG_OIL_ACTIVE_LOW = 3'd1,
    REG_OIL_MIN        = 3'd2,
    REG_OIL_MAX        = 3'd3,
    REG_OIL_STARTUP    = 3'd4,
    REG_LIMP_RECOVERY  = 3'd5,
    REG_LIMP_CAP       = 3'd6
  } reg_idx_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [1:0]         oil_mode;
    logic               oil_switch_active_low;
    logic [11:0]        oil_min_psi_tenths;
    logic [7:0]         oil_max_psi;
    logic [15:0]        oil_startup_ms;
    logic [15:0]        limp_recovery_ms;
    logic signed [10:0] limp_advance_cap_tenths;
  } cfg_t;

  // Scaled sender numerator (10*sample - 4095) * max_psi, negative values as zero.
  function automatic logic [23:0] oil_scaled_num(logic [11:0] sample, logic [7:0] max_psi);
    logic signed [17:0] off;
    logic signed [26:0] prod;
    off  = $signed({2'b00, 16'(sample) * 16'd10}) - ADC_OFFSET_X10;
    prod = off * $signed({1'b0, max_psi});
    return prod[26] ? 24'd0 : prod[23:0];
  endfunction

  // Floor of n / 3276, done as (n / 4) / 819 with a reciprocal multiply.
  function automatic logic [11:0] oil_div_3276(logic [23:0] n);
    logic [44:0] prod;
    prod = {23'd0, n[23:2]} * {22'd0, DIV819_RECIP};
    return prod[43:32];
  endfunction

endpackage

`default_nettype wire

>>> design/opls_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module opls_regs
  import opls_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  // Register writes; addresses beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.oil_mode                <= OIL_OFF;
      cfg_q.oil_switch_active_low   <= 1'b1;
      cfg_q.oil_min_psi_tenths      <= 12'd100;
      cfg_q.oil_max_psi             <= 8'd100;
      cfg_q.oil_startup_ms          <= 16'd3000;
      cfg_q.limp_recovery_ms        <= 16'd5000;
      cfg_q.limp_advance_cap_tenths <= 11'sd100;
    end else if (wr_en) begin
      case (idx)
        REG_OIL_MODE:       cfg_q.oil_mode                <= pwdata[1:0];
        REG_OIL_ACTIVE_LOW: cfg_q.oil_switch_active_low   <= pwdata[0];
        REG_OIL_MIN:        cfg_q.oil_min_psi_tenths      <= pwdata[11:0];
        REG_OIL_MAX:        cfg_q.oil_max_psi             <= pwdata[7:0];
        REG_OIL_STARTUP:    cfg_q.oil_startup_ms          <= pwdata[15:0];
        REG_LIMP_RECOVERY:  cfg_q.limp_recovery_ms        <= pwdata[15:0];
        REG_LIMP_CAP:       cfg_q.limp_advance_cap_tenths <= $signed(pwdata[10:0]);
        default: ;
      endcase
    end
  end

  // Read back, zero-extended to the bus width.
  always_comb begin
    case (idx)
      REG_OIL_MODE:       prdata = {30'd0, cfg_q.oil_mode};
      REG_OIL_ACTIVE_LOW: prdata = {31'd0, cfg_q.oil_switch_active_low};
      REG_OIL_MIN:        prdata = {20'd0, cfg_q.oil_min_psi_tenths};
      REG_OIL_MAX:        prdata = {24'd0, cfg_q.oil_max_psi};
      REG_OIL_STARTUP:    prdata = {16'd0, cfg_q.oil_startup_ms};
      REG_LIMP_RECOVERY:  prdata = {16'd0, cfg_q.limp_recovery_ms};
      REG_LIMP_CAP:       prdata = {21'd0, cfg_q.limp_advance_cap_tenths};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

>>> design/opls_oil.sv
// Oil pressure monitor: startup hold-off, switch or sender reading, held state.
`default_nettype none

module opls_oil
  import opls_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire logic        step_i,
  input  wire logic        running_i,
  input  wire logic        switch_level_i,
  input  wire logic [23:0] scaled_num_i,
  input  wire logic [31:0] now_ms_i,
  output logic             oil_low_o,
  output logic      [11:0] oil_psi_o
);

  logic        was_running_q, was_running_d;
  logic [31:0] run_start_q, run_start_d;
  logic        low_q, low_d;
  logic [11:0] psi_q, psi_d;

  logic        mode_en;
  logic [31:0] elapsed;
  logic [11:0] full_scale;
  logic [11:0] quotient;
  logic [11:0] analog_psi;
  logic        switch_low;

  assign mode_en    = (cfg_i.oil_mode == OIL_SWITCH) || (cfg_i.oil_mode == OIL_ANALOG);
  assign full_scale = 12'(cfg_i.oil_max_psi) * 12'd10;
  assign quotient   = oil_div_3276(scaled_num_i);
  assign analog_psi = (quotient > full_scale) ? full_scale : quotient;
  assign switch_low = cfg_i.oil_switch_active_low ? !switch_level_i : switch_level_i;
  assign elapsed    = now_ms_i - run_start_d;

  // Next oil state for the item in hand.
  always_comb begin
    was_running_d = was_running_q;
    run_start_d   = run_start_q;
    low_d         = low_q;
    psi_d         = psi_q;
    if (mode_en) begin
      if (!running_i) begin
        was_running_d = 1'b0;
        low_d         = 1'b0;
        psi_d         = 12'd0;
      end else begin
        if (!was_running_q) begin
          run_start_d = now_ms_i;
        end
        was_running_d = 1'b1;
        if (elapsed >= {16'd0, cfg_i.oil_startup_ms}) begin
          if (cfg_i.oil_mode == OIL_SWITCH) begin
            low_d = switch_low;
            psi_d = switch_low ? 12'd0 : full_scale;
          end else begin
            low_d = analog_psi < cfg_i.oil_min_psi_tenths;
            psi_d = analog_psi;
          end
        end
      end
    end
  end

  // The low-pressure flag doubles as the oil fault flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_running_q <= 1'b0;
      run_start_q   <= 32'd0;
      low_q         <= 1'b0;
      psi_q         <= 12'd0;
    end else if (step_i) begin
      was_running_q <= was_running_d;
      run_start_q   <= run_start_d;
      low_q         <= low_d;
      psi_q         <= psi_d;
    end
  end

  assign oil_low_o = low_d;
  assign oil_psi_o = psi_d;

endmodule

`default_nettype wire

>>> design/opls_limp.sv
// Limp latch with recovery timer, and the spark advance cap while limp.
`default_nettype none

module opls_limp
  import opls_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               step_i,
  input  wire logic        [7:0]  faults_i,
  input  wire logic        [31:0] now_ms_i,
  input  wire logic signed [10:0] advance_i,
  output logic                    limp_o,
  output logic             [7:0]  fault_bits_o,
  output logic                    entered_o,
  output logic                    cleared_o,
  output logic signed      [10:0] advance_o
);

  logic        latch_q, latch_d;
  logic [7:0]  faults_q, faults_d;
  logic        rec_run_q, rec_run_d;
  logic [31:0] rec_start_q, rec_start_d;
  logic [31:0] rec_elapsed;

  assign rec_elapsed = now_ms_i - rec_start_q;

  // Latch on any fault; release after a fault-free recovery time.
  always_comb begin
    latch_d     = latch_q;
    faults_d    = faults_q;
    rec_run_d   = rec_run_q;
    rec_start_d = rec_start_q;
    entered_o   = 1'b0;
    cleared_o   = 1'b0;
    if (faults_i != 8'd0) begin
      rec_run_d = 1'b0;
      latch_d   = 1'b1;
      entered_o = !latch_q;
      faults_d  = faults_i;
    end else if (latch_q) begin
      if (!rec_run_q) begin
        rec_start_d = now_ms_i;
        rec_run_d   = 1'b1;
      end else if (rec_elapsed >= {16'd0, cfg_i.limp_recovery_ms}) begin
        latch_d   = 1'b0;
        faults_d  = 8'd0;
        rec_run_d = 1'b0;
        cleared_o = 1'b1;
      end
    end
  end

  // Advance cap while limp: below the floor gives the floor, else at most the cap.
  always_comb begin
    advance_o = advance_i;
    if (latch_d) begin
      if (advance_i < ADV_FLOOR) begin
        advance_o = ADV_FLOOR;
      end else if (advance_i > cfg_i.limp_advance_cap_tenths) begin
        advance_o = cfg_i.limp_advance_cap_tenths;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_q     <= 1'b0;
      faults_q    <= 8'd0;
      rec_run_q   <= 1'b0;
      rec_start_q <= 32'd0;
    end else if (step_i) begin
      latch_q     <= latch_d;
      faults_q    <= faults_d;
      rec_run_q   <= rec_run_d;
      rec_start_q <= rec_start_d;
    end
  end

  assign limp_o       = latch_d;
  assign fault_bits_o = faults_d;

endmodule

`default_nettype wire

>>> design/oil_pressure_limp_supervisor.sv
// Top level of the oil pressure and limp mode supervisor.
// Each control tick is one input item and gives exactly one result item. An
// item is registered on acceptance together with the sender scaling product,
// is evaluated against the held oil and limp state from the input register,
// and its result lands in the output register when that register is free, so
// one item is accepted in every cycle unless the output stalls. The sustained
// rate of one item per cycle is set by the single state update per item in the
// oil and limp registers; a stalled output holds one result while the input
// register keeps one more item. Configuration is written through the APB-style
// port, always ready, and should only change while no item is in flight.
`default_nettype none

module oil_pressure_limp_supervisor
  import opls_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic        [4:0]  paddr,
  input  wire logic        [31:0] pwdata,
  output logic             [31:0] prdata,
  output logic                    pready,
  // Input channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic        [15:0] engine_rpm_i,
  input  wire logic        [7:0]  sensor_fault_bits_i,
  input  wire logic               expander_fault_i,
  input  wire logic               oil_switch_level_i,
  input  wire logic        [11:0] oil_adc_sample_i,
  input  wire logic        [31:0] now_ms_i,
  input  wire logic signed [10:0] advance_in_tenths_i,
  // Result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic             [1:0]  engine_state_o,
  output logic             [11:0] oil_psi_tenths_o,
  output logic                    oil_low_o,
  output logic                    limp_active_o,
  output logic             [7:0]  limp_fault_bits_o,
  output logic                    limp_entered_o,
  output logic                    limp_cleared_o,
  output logic signed      [10:0] advance_out_tenths_o
);

  cfg_t cfg;

  // Input register
  logic               s1_valid_q;
  logic [15:0]        s1_rpm_q;
  logic [7:0]         s1_sensor_q;
  logic               s1_expander_q;
  logic               s1_level_q;
  logic [23:0]        s1_num_q;
  logic [31:0]        s1_now_q;
  logic signed [10:0] s1_adv_q;

  logic               in_accept;
  logic               s1_step;

  // Evaluation signals
  engine_state_e      estate;
  logic               oil_low;
  logic [11:0]        oil_psi;
  logic [7:0]         fault_word;
  logic               limp;
  logic [7:0]         limp_bits;
  logic               entered;
  logic               cleared;
  logic signed [10:0] adv_out;

  // Output register
  logic               out_valid_q;
  logic [1:0]         out_state_q;
  logic [11:0]        out_psi_q;
  logic               out_low_q;
  logic               out_limp_q;
  logic [7:0]         out_bits_q;
  logic               out_entered_q;
  logic               out_cleared_q;
  logic signed [10:0] out_adv_q;

  opls_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Handshake: the input register moves on whenever the output register is free.
  assign s1_step    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_step;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_step) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Capture the item and the sender scaling product.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_rpm_q      <= engine_rpm_i;
      s1_sensor_q   <= sensor_fault_bits_i;
      s1_expander_q <= expander_fault_i;
      s1_level_q    <= oil_switch_level_i;
      s1_num_q      <= oil_scaled_num(oil_adc_sample_i, cfg.oil_max_psi);
      s1_now_q      <= now_ms_i;
      s1_adv_q      <= advance_in_tenths_i;
    end
  end

  // Engine classification.
  always_comb begin
    if (s1_rpm_q == 16'd0) begin
      estate = ENG_OFF;
    end else if (s1_rpm_q < RUN_RPM) begin
      estate = ENG_CRANK;
    end else begin
      estate = ENG_RUN;
    end
  end

  opls_oil u_oil (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .step_i         (s1_step),
    .running_i      (estate == ENG_RUN),
    .switch_level_i (s1_level_q),
    .scaled_num_i   (s1_num_q),
    .now_ms_i       (s1_now_q),
    .oil_low_o      (oil_low),
    .oil_psi_o      (oil_psi)
  );

  // Combined fault word for this item.
  assign fault_word = s1_sensor_q
                    | (s1_expander_q ? FAULT_EXPANDER_BIT : 8'd0)
                    | (oil_low ? FAULT_OIL_BIT : 8'd0);

  opls_limp u_limp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .step_i       (s1_step),
    .faults_i     (fault_word),
    .now_ms_i     (s1_now_q),
    .advance_i    (s1_adv_q),
    .limp_o       (limp),
    .fault_bits_o (limp_bits),
    .entered_o    (entered),
    .cleared_o    (cleared),
    .advance_o    (adv_out)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_step) begin
      out_state_q   <= estate;
      out_psi_q     <= oil_psi;
      out_low_q     <= oil_low;
      out_limp_q    <= limp;
      out_bits_q    <= limp_bits;
      out_entered_q <= entered;
      out_cleared_q <= cleared;
      out_adv_q     <= adv_out;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign engine_state_o       = out_state_q;
  assign oil_psi_tenths_o     = out_psi_q;
  assign oil_low_o            = out_low_q;
  assign limp_active_o        = out_limp_q;
  assign limp_fault_bits_o    = out_bits_q;
  assign limp_entered_o       = out_entered_q;
  assign limp_cleared_o       = out_cleared_q;
  assign advance_out_tenths_o = out_adv_q;

endmodule

`default_nettype wire

>>> design/opls_checker.sv
// Port-level assertions for the supervisor and the bind that attaches them.
`default_nettype none

module opls_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic               limp_active_o,
  input wire logic        [7:0]  limp_fault_bits_o,
  input wire logic               limp_entered_o,
  input wire logic               limp_cleared_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // An entry pulse comes with the latch set, never together with a clear.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limp_entered_o |-> limp_active_o && !limp_cleared_o)
    else $error("limp entry without latch");

  // Outside limp no fault bits are reported.
  a_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !limp_active_o |-> limp_fault_bits_o == 8'd0)
    else $error("fault bits shown while not limp");

  // A release pulse comes with the latch open and the fault bits cleared.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && limp_cleared_o |-> !limp_active_o && limp_fault_bits_o == 8'd0)
    else $error("limp release with latch still set");

endmodule

bind oil_pressure_limp_supervisor opls_checker u_opls_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .limp_active_o     (limp_active_o),
  .limp_fault_bits_o (limp_fault_bits_o),
  .limp_entered_o    (limp_entered_o),
  .limp_cleared_o    (limp_cleared_o)
);

`default_nettype wire
